/* rtl/core/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the buffer pool controller modules.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int FRAMES = 16;
  localparam int FIDX_W = $clog2(FRAMES);
  localparam int LINK_W = $clog2(FRAMES + 1);
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int FILE_W = 4;
  localparam int PAGE_W = 32;
  localparam int PIN_W  = 8;

  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(FRAMES);
  localparam logic [PIN_W-1:0]  PIN_MAX   = {PIN_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_INSTALL = 3'd2,
    CMD_FREE    = 3'd3,
    CMD_RELEASE = 3'd4,
    CMD_FLUSH   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_PINNED   = 2'd2,
    ST_ABSENT   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_DONE = 1'b0,
    KIND_WB   = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_VRD,
    S_VCK,
    S_WB,
    S_UNLINK,
    S_LINK,
    S_FACT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]        command;
    logic [FILE_W-1:0] file_id;
    logic [PAGE_W-1:0] page_number;
    logic              drop_after_flush;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [FIDX_W-1:0] frame_no;
    logic [FILE_W-1:0] out_file_id;
    logic [PAGE_W-1:0] out_page_number;
    logic              hit;
    logic              fill_needed;
    logic [1:0]        status;
    logic              last;
  } rsp_t;

  // per-frame record held in the frame memory
  typedef struct packed {
    logic              dirty;
    logic [PIN_W-1:0]  pins;
    logic [FILE_W-1:0] file;
    logic [PAGE_W-1:0] page;
  } rec_t;

  typedef struct packed {
    logic              init;
    logic              unlink;
    logic              link;
    logic [FIDX_W-1:0] frame;
  } lru_ctl_t;

  typedef struct packed {
    logic              init;
    logic              pop;
    logic              push;
    logic [FIDX_W-1:0] frame;
    logic [CNT_W-1:0]  n;
  } fs_ctl_t;

endpackage

/* rtl/core/bpc_rec_mem.sv */
// ----------------------------------------------------------------------------
// bpc_rec_mem
// Frame record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bpc_rec_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [bpc_pkg::FIDX_W-1:0]     waddr_i,
  input  bpc_pkg::rec_t                  wdata_i,
  input  logic [bpc_pkg::FIDX_W-1:0]     raddr_i,
  output bpc_pkg::rec_t                  rdata_o
);

  bpc_pkg::rec_t mem [bpc_pkg::FRAMES];
  bpc_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bpc_lru.sv */
// ----------------------------------------------------------------------------
// bpc_lru
// Doubly linked recency list over the frames, oldest to newest.
// ----------------------------------------------------------------------------
module bpc_lru (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpc_pkg::lru_ctl_t             ctl_i,
  input  logic [bpc_pkg::FIDX_W-1:0]    rd_frame_i,
  output logic [bpc_pkg::LINK_W-1:0]    oldest_o,
  output logic [bpc_pkg::LINK_W-1:0]    newer_o
);

  logic [bpc_pkg::LINK_W-1:0] older_q [bpc_pkg::FRAMES];
  logic [bpc_pkg::LINK_W-1:0] newer_q [bpc_pkg::FRAMES];
  logic [bpc_pkg::LINK_W-1:0] oldest_q, newest_q;
  logic [bpc_pkg::LINK_W-1:0] un_o, un_w;

  assign un_o = older_q[ctl_i.frame];
  assign un_w = newer_q[ctl_i.frame];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= bpc_pkg::NONE_LINK;
      newest_q <= bpc_pkg::NONE_LINK;
    end else if (ctl_i.init) begin
      oldest_q <= bpc_pkg::NONE_LINK;
      newest_q <= bpc_pkg::NONE_LINK;
    end else if (ctl_i.unlink) begin
      if (un_o >= bpc_pkg::NONE_LINK) oldest_q <= un_w;
      if (un_w >= bpc_pkg::NONE_LINK) newest_q <= un_o;
    end else if (ctl_i.link) begin
      if (newest_q >= bpc_pkg::NONE_LINK) oldest_q <= bpc_pkg::LINK_W'(ctl_i.frame);
      newest_q <= bpc_pkg::LINK_W'(ctl_i.frame);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.unlink) begin
      if (un_o < bpc_pkg::NONE_LINK) newer_q[un_o[bpc_pkg::FIDX_W-1:0]] <= un_w;
      if (un_w < bpc_pkg::NONE_LINK) older_q[un_w[bpc_pkg::FIDX_W-1:0]] <= un_o;
    end else if (ctl_i.link) begin
      older_q[ctl_i.frame] <= newest_q;
      newer_q[ctl_i.frame] <= bpc_pkg::NONE_LINK;
      // newest is never the frame being linked, so the two writes differ
      if (newest_q < bpc_pkg::NONE_LINK) begin
        newer_q[newest_q[bpc_pkg::FIDX_W-1:0]] <= bpc_pkg::LINK_W'(ctl_i.frame);
      end
    end
  end

  assign oldest_o = oldest_q;
  assign newer_o  = newer_q[rd_frame_i];

endmodule

/* rtl/core/bpc_free_stack.sv */
// ----------------------------------------------------------------------------
// bpc_free_stack
// Stack of free frame indexes, refilled on reset and pool setup.
// ----------------------------------------------------------------------------
module bpc_free_stack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpc_pkg::fs_ctl_t              ctl_i,
  output logic [bpc_pkg::FIDX_W-1:0]    top_o,
  output logic [bpc_pkg::CNT_W-1:0]     count_o
);

  logic [bpc_pkg::FIDX_W-1:0] stack_q [bpc_pkg::FRAMES];
  logic [bpc_pkg::CNT_W-1:0]  count_q;
  logic [bpc_pkg::CNT_W-1:0]  top_idx;

  function automatic logic [bpc_pkg::FIDX_W-1:0] fill_entry(
    input logic [bpc_pkg::CNT_W-1:0] n, input int k);
    logic [bpc_pkg::CNT_W-1:0] kk;
    kk = bpc_pkg::CNT_W'(k);
    return (kk < n) ? bpc_pkg::FIDX_W'(n - kk - bpc_pkg::CNT_W'(1)) : '0;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= bpc_pkg::CNT_W'(bpc_pkg::FRAMES);
      for (int k = 0; k < bpc_pkg::FRAMES; k++) begin
        stack_q[k] <= fill_entry(bpc_pkg::CNT_W'(bpc_pkg::FRAMES), k);
      end
    end else if (ctl_i.init) begin
      count_q <= ctl_i.n;
      for (int k = 0; k < bpc_pkg::FRAMES; k++) begin
        stack_q[k] <= fill_entry(ctl_i.n, k);
      end
    end else if (ctl_i.pop) begin
      count_q <= top_idx;
    end else if (ctl_i.push && count_q < bpc_pkg::CNT_W'(bpc_pkg::FRAMES)) begin
      stack_q[count_q[bpc_pkg::FIDX_W-1:0]] <= ctl_i.frame;
      count_q <= count_q + bpc_pkg::CNT_W'(1);
    end
  end

  assign top_idx = count_q - bpc_pkg::CNT_W'(1);
  assign top_o   = stack_q[top_idx[bpc_pkg::FIDX_W-1:0]];
  assign count_o = count_q;

endmodule

/* rtl/core/lru_page_buffer_pool_controller.sv */
// ----------------------------------------------------------------------------
// lru_page_buffer_pool_controller
// Tag and replacement engine for a fully associative page buffer with pin
// counts, dirty bits, a free stack and LRU eviction of unpinned frames.
//
//   channel   signals                          transfer when
//   request   start, busy, req_i               start & !busy
//   result    rsp_valid_o, rsp_o               rsp_valid_o (one cycle each)
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i   cfg_valid_i & cfg_ready_o
//
// Sequence: the frame memory is scanned one entry per cycle (a hit stops
// early), then relink and completion; a miss with an empty free stack walks
// the LRU list from the oldest frame, reading and checking each frame and
// passing pinned ones, with a write-back for a dirty victim. Flush adds a
// step per matching frame. Each result is held one cycle and cannot be stalled.
// Reset and a config write empty the pool at once; no clearing pass.
// ----------------------------------------------------------------------------
module lru_page_buffer_pool_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bpc_pkg::req_t        req_i,
  output logic                 rsp_valid_o,
  output bpc_pkg::rsp_t        rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [4:0]           cfg_data_i
);

  localparam int FW = bpc_pkg::FIDX_W;
  localparam int CW = bpc_pkg::CNT_W;

  bpc_pkg::state_e state_q, state_d;
  bpc_pkg::req_t   req_q, req_d;
  bpc_pkg::rec_t   cur_rec_q, cur_rec_d, rd_rec, wr_rec;
  bpc_pkg::rsp_t   rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;

  logic [bpc_pkg::FRAMES-1:0] valid_q, valid_d;
  logic [CW-1:0]   fiu_q, fiu_new;
  logic [CW-1:0]   idx_q, idx_d;
  logic            chk_v_q, chk_v_d;
  logic [FW-1:0]   chk_idx_q, chk_idx_d;
  logic [FW-1:0]   cur_f_q, cur_f_d;
  logic            hit_q, hit_d, fill_q, fill_d;
  logic [1:0]      st_q, st_d;
  logic [bpc_pkg::LINK_W-1:0] vic_q, vic_d;
  logic [CW-1:0]   steps_q, steps_d;

  logic            mem_we;
  logic [FW-1:0]   mem_raddr;
  bpc_pkg::lru_ctl_t lru_ctl;
  bpc_pkg::fs_ctl_t  fs_ctl;
  logic [bpc_pkg::LINK_W-1:0] lru_oldest, lru_newer;
  logic [FW-1:0]   fs_top;
  logic [CW-1:0]   fs_count;

  logic cfg_we, accept, is_flush, is_lookup, match, scan_end;

  assign busy        = (state_q != bpc_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == bpc_pkg::S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = start && !busy;

  // out-of-range pool sizes clamp to 1..FRAMES
  always_comb begin
    fiu_new = cfg_data_i;
    if (cfg_data_i == '0) fiu_new = CW'(1);
    else if (cfg_data_i > CW'(bpc_pkg::FRAMES)) fiu_new = CW'(bpc_pkg::FRAMES);
  end

  assign is_flush  = (req_q.command == bpc_pkg::CMD_FLUSH);
  assign is_lookup = (req_q.command == bpc_pkg::CMD_READ) ||
                     (req_q.command == bpc_pkg::CMD_WRITE) ||
                     (req_q.command == bpc_pkg::CMD_INSTALL);

  assign match = chk_v_q && valid_q[chk_idx_q] && (rd_rec.file == req_q.file_id) &&
                 (is_flush || rd_rec.page == req_q.page_number);
  assign scan_end = !match && ((chk_v_q && chk_idx_q == FW'(bpc_pkg::FRAMES - 1)) ||
                               (!chk_v_q && idx_q == CW'(bpc_pkg::FRAMES)));

  assign mem_raddr = (state_q == bpc_pkg::S_SCAN) ? idx_q[FW-1:0] : vic_q[FW-1:0];

  bpc_rec_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cur_f_q),
    .wdata_i (wr_rec),
    .raddr_i (mem_raddr),
    .rdata_o (rd_rec)
  );

  bpc_lru u_lru (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lru_ctl),
    .rd_frame_i (vic_q[FW-1:0]),
    .oldest_o   (lru_oldest),
    .newer_o    (lru_newer)
  );

  bpc_free_stack u_fs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fs_ctl),
    .top_o   (fs_top),
    .count_o (fs_count)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpc_pkg::S_IDLE: begin
        if (accept) begin
          if (req_i.command > bpc_pkg::CMD_FLUSH) state_d = bpc_pkg::S_DONE;
          else state_d = bpc_pkg::S_SCAN;
        end
      end
      bpc_pkg::S_SCAN: begin
        if (match) begin
          if (is_flush) state_d = bpc_pkg::S_FACT;
          else if (is_lookup) state_d = bpc_pkg::S_UNLINK;
          else if (req_q.command == bpc_pkg::CMD_FREE) begin
            if (rd_rec.pins != '0) state_d = bpc_pkg::S_DONE;
            else if (rd_rec.dirty) state_d = bpc_pkg::S_WB;
            else state_d = bpc_pkg::S_UNLINK;
          end else state_d = bpc_pkg::S_DONE;
        end else if (scan_end) begin
          if (is_lookup) begin
            state_d = (fs_count != '0) ? bpc_pkg::S_LINK : bpc_pkg::S_VRD;
          end else state_d = bpc_pkg::S_DONE;
        end
      end
      bpc_pkg::S_VRD: begin
        state_d = (vic_q >= bpc_pkg::NONE_LINK) ? bpc_pkg::S_DONE : bpc_pkg::S_VCK;
      end
      bpc_pkg::S_VCK: begin
        if (rd_rec.pins != '0) begin
          state_d = (steps_q < CW'(bpc_pkg::FRAMES)) ? bpc_pkg::S_VRD : bpc_pkg::S_DONE;
        end else if (rd_rec.dirty) state_d = bpc_pkg::S_WB;
        else state_d = bpc_pkg::S_UNLINK;
      end
      bpc_pkg::S_WB:     state_d = bpc_pkg::S_UNLINK;
      bpc_pkg::S_UNLINK: state_d = is_lookup ? bpc_pkg::S_LINK : bpc_pkg::S_DONE;
      bpc_pkg::S_LINK:   state_d = bpc_pkg::S_DONE;
      bpc_pkg::S_FACT:   state_d = bpc_pkg::S_SCAN;
      bpc_pkg::S_DONE:   state_d = bpc_pkg::S_IDLE;
      default:           state_d = bpc_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d       = req_q;
    cur_rec_d   = cur_rec_q;
    valid_d     = valid_q;
    idx_d       = idx_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    cur_f_d     = cur_f_q;
    hit_d       = hit_q;
    fill_d      = fill_q;
    st_d        = st_q;
    vic_d       = vic_q;
    steps_d     = steps_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    wr_rec      = cur_rec_q;
    lru_ctl     = '{init: cfg_we, unlink: 1'b0, link: 1'b0, frame: cur_f_q};
    fs_ctl      = '{init: cfg_we, pop: 1'b0, push: 1'b0, frame: cur_f_q, n: fiu_new};

    unique case (state_q)
      bpc_pkg::S_IDLE: begin
        if (accept) begin
          req_d   = req_i;
          idx_d   = '0;
          cur_f_d = '0;
          hit_d   = 1'b0;
          fill_d  = 1'b0;
          st_d    = bpc_pkg::ST_OK;
        end
      end
      bpc_pkg::S_SCAN: begin
        if (match) begin
          cur_f_d   = chk_idx_q;
          cur_rec_d = rd_rec;
          if (!is_flush) hit_d = 1'b1;
          if (req_q.command == bpc_pkg::CMD_FREE && rd_rec.pins != '0) begin
            st_d = bpc_pkg::ST_PINNED;
          end
        end else if (scan_end) begin
          if (is_lookup) begin
            if (fs_count != '0) begin
              cur_f_d    = fs_top;
              fill_d     = 1'b1;
              fs_ctl.pop = 1'b1;
            end else begin
              vic_d   = lru_oldest;
              steps_d = '0;
            end
          end else if (!is_flush) begin
            st_d = bpc_pkg::ST_ABSENT;
          end
        end else begin
          chk_v_d   = (idx_q != CW'(bpc_pkg::FRAMES));
          chk_idx_d = idx_q[FW-1:0];
          if (idx_q != CW'(bpc_pkg::FRAMES)) idx_d = idx_q + CW'(1);
        end
      end
      bpc_pkg::S_VRD: begin
        if (vic_q >= bpc_pkg::NONE_LINK) st_d = bpc_pkg::ST_NO_FRAME;
      end
      bpc_pkg::S_VCK: begin
        if (rd_rec.pins != '0) begin
          if (steps_q < CW'(bpc_pkg::FRAMES)) begin
            vic_d   = lru_newer;
            steps_d = steps_q + CW'(1);
          end else st_d = bpc_pkg::ST_NO_FRAME;
        end else begin
          cur_f_d   = vic_q[FW-1:0];
          cur_rec_d = rd_rec;
          fill_d    = 1'b1;
        end
      end
      bpc_pkg::S_WB: begin
        rsp_valid_d = 1'b1;
        rsp_d = '{kind: bpc_pkg::KIND_WB, frame_no: cur_f_q,
                  out_file_id: cur_rec_q.file, out_page_number: cur_rec_q.page,
                  hit: 1'b0, fill_needed: 1'b0, status: bpc_pkg::ST_OK, last: 1'b0};
      end
      bpc_pkg::S_UNLINK: begin
        lru_ctl.unlink   = 1'b1;
        valid_d[cur_f_q] = 1'b0;
        // free: frame goes back to the stack
        if (!is_lookup) fs_ctl.push = 1'b1;
      end
      bpc_pkg::S_LINK: begin
        lru_ctl.link     = 1'b1;
        valid_d[cur_f_q] = 1'b1;
        mem_we           = 1'b1;
        if (hit_q) begin
          wr_rec.dirty = cur_rec_q.dirty || (req_q.command == bpc_pkg::CMD_WRITE);
          if (req_q.command == bpc_pkg::CMD_READ && cur_rec_q.pins != bpc_pkg::PIN_MAX) begin
            wr_rec.pins = cur_rec_q.pins + bpc_pkg::PIN_W'(1);
          end
        end else begin
          wr_rec.dirty = (req_q.command == bpc_pkg::CMD_WRITE);
          wr_rec.pins  = (req_q.command == bpc_pkg::CMD_READ) ? bpc_pkg::PIN_W'(1) : '0;
          wr_rec.file  = req_q.file_id;
          wr_rec.page  = req_q.page_number;
        end
      end
      bpc_pkg::S_FACT: begin
        if (cur_rec_q.dirty) begin
          rsp_valid_d  = 1'b1;
          rsp_d = '{kind: bpc_pkg::KIND_WB, frame_no: cur_f_q,
                    out_file_id: cur_rec_q.file, out_page_number: cur_rec_q.page,
                    hit: 1'b0, fill_needed: 1'b0, status: bpc_pkg::ST_OK, last: 1'b0};
          mem_we       = 1'b1;
          wr_rec.dirty = 1'b0;
        end
        if (req_q.drop_after_flush) begin
          if (cur_rec_q.pins != '0) st_d = bpc_pkg::ST_PINNED;
          else begin
            lru_ctl.unlink   = 1'b1;
            valid_d[cur_f_q] = 1'b0;
            fs_ctl.push      = 1'b1;
          end
        end
        idx_d = CW'(cur_f_q) + CW'(1);
      end
      bpc_pkg::S_DONE: begin
        if (req_q.command == bpc_pkg::CMD_RELEASE && hit_q) begin
          mem_we = 1'b1;
          if (cur_rec_q.pins != '0) wr_rec.pins = cur_rec_q.pins - bpc_pkg::PIN_W'(1);
        end
        rsp_valid_d = 1'b1;
        rsp_d = '{kind: bpc_pkg::KIND_DONE, frame_no: is_flush ? '0 : cur_f_q,
                  out_file_id: req_q.file_id,
                  out_page_number: is_flush ? '0 : req_q.page_number,
                  hit: hit_q, fill_needed: fill_q, status: st_q, last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpc_pkg::S_IDLE;
      valid_q     <= '0;
      fiu_q       <= CW'(bpc_pkg::FRAMES);
      rsp_valid_q <= 1'b0;
      chk_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      chk_v_q     <= chk_v_d;
      if (cfg_we) begin
        fiu_q   <= fiu_new;
        valid_q <= '0;
      end else begin
        valid_q <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cur_rec_q <= cur_rec_d;
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
    cur_f_q   <= cur_f_d;
    hit_q     <= hit_d;
    fill_q    <= fill_d;
    st_q      <= st_d;
    vic_q     <= vic_d;
    steps_q   <= steps_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_count <= fiu_q) else $error("free stack holds more frames than the pool");

  a_install_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpc_pkg::S_LINK && !hit_q) |-> !valid_q[cur_f_q])
    else $error("miss installs into a resident frame");

  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpc_pkg::S_VCK) |-> $past(state_q == bpc_pkg::S_VRD))
    else $error("victim check without a read");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.last) |-> $past(state_q == bpc_pkg::S_DONE))
    else $error("completion outside the done step");

endmodule

/* tb/lru_page_buffer_pool_controller_tb.sv */
// ----------------------------------------------------------------------------
// lru_page_buffer_pool_controller_tb
// Self-checking bench for the buffer pool controller. A behavioral copy of
// the pool (frames, pins, dirty bits, LRU list, free stack) predicts each
// result. Directed tests cover commands and corner cases, then random
// traffic runs under several pool sizes with random start gaps.
// ----------------------------------------------------------------------------
module lru_page_buffer_pool_controller_tb;

  localparam int NONE = bpc_pkg::FRAMES;
  localparam int CYCLE_LIMIT = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  bpc_pkg::req_t req_i = '0;
  logic          rsp_valid_o;
  bpc_pkg::rsp_t rsp_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [4:0]    cfg_data_i = '0;

  lru_page_buffer_pool_controller u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // pool mirror
  int                         pool_size;
  bit                         fr_valid [bpc_pkg::FRAMES];
  bit                         fr_dirty [bpc_pkg::FRAMES];
  int                         fr_pins  [bpc_pkg::FRAMES];
  logic [bpc_pkg::FILE_W-1:0] fr_file  [bpc_pkg::FRAMES];
  logic [bpc_pkg::PAGE_W-1:0] fr_page  [bpc_pkg::FRAMES];
  int                         older [bpc_pkg::FRAMES];
  int                         newer [bpc_pkg::FRAMES];
  int                         lru_head, mru_tail;
  int                         free_stk [bpc_pkg::FRAMES];
  int                         free_cnt;

  bpc_pkg::rsp_t pending_rsp[$];
  int   fail_cnt = 0;
  int   cycle_cnt = 0;

  function automatic void pool_clear();
    for (int k = 0; k < bpc_pkg::FRAMES; k++) begin
      fr_valid[k] = 0; fr_dirty[k] = 0; fr_pins[k] = 0;
      fr_file[k] = '0; fr_page[k] = '0; older[k] = 0; newer[k] = 0;
      free_stk[k] = 0;
    end
    lru_head = NONE; mru_tail = NONE;
    for (int k = 0; k < pool_size; k++) free_stk[k] = pool_size - 1 - k;
    free_cnt = pool_size;
  endfunction

  function automatic void list_unlink(int f);
    int o, w;
    o = older[f]; w = newer[f];
    if (o < bpc_pkg::FRAMES) newer[o] = w; else lru_head = w;
    if (w < bpc_pkg::FRAMES) older[w] = o; else mru_tail = o;
  endfunction

  function automatic void list_append(int f);
    older[f] = mru_tail; newer[f] = NONE;
    if (mru_tail < bpc_pkg::FRAMES) newer[mru_tail] = f; else lru_head = f;
    mru_tail = f;
  endfunction

  function automatic void frame_drop(int f);
    list_unlink(f);
    fr_valid[f] = 0; fr_dirty[f] = 0; fr_pins[f] = 0;
  endfunction

  function automatic void free_push(int f);
    if (free_cnt < bpc_pkg::FRAMES) begin
      free_stk[free_cnt] = f; free_cnt++;
    end
  endfunction

  function automatic void add_rsp(bpc_pkg::kind_e kd, int f,
                                  logic [bpc_pkg::FILE_W-1:0] fid,
                                  logic [bpc_pkg::PAGE_W-1:0] pg, bit h, bit fl,
                                  bpc_pkg::status_e st, bit lst);
    bpc_pkg::rsp_t r;
    r.kind = kd; r.frame_no = f[bpc_pkg::FIDX_W-1:0]; r.out_file_id = fid;
    r.out_page_number = pg; r.hit = h; r.fill_needed = fl; r.status = st;
    r.last = lst;
    pending_rsp.push_back(r);
  endfunction

  function automatic void add_writeback(int f);
    add_rsp(bpc_pkg::KIND_WB, f, fr_file[f], fr_page[f], 0, 0, bpc_pkg::ST_OK, 0);
  endfunction

  function automatic int find_page(logic [bpc_pkg::FILE_W-1:0] fid,
                                   logic [bpc_pkg::PAGE_W-1:0] pg);
    for (int f = 0; f < bpc_pkg::FRAMES; f++)
      if (fr_valid[f] && fr_file[f] == fid && fr_page[f] == pg) return f;
    return NONE;
  endfunction

  function automatic void predict_request(bpc_pkg::req_t q);
    int  f, steps;
    bit  was_hit;
    bpc_pkg::status_e st;
    if (q.command <= bpc_pkg::CMD_INSTALL) begin
      f = find_page(q.file_id, q.page_number);
      was_hit = (f != NONE);
      if (!was_hit) begin
        if (free_cnt > 0) begin
          free_cnt--; f = free_stk[free_cnt];
          if (f >= bpc_pkg::FRAMES) f = 0;
        end else begin
          f = lru_head; steps = 0;
          while (steps < bpc_pkg::FRAMES && f < bpc_pkg::FRAMES && fr_pins[f] != 0) begin
            f = newer[f]; steps++;
          end
          if (f >= bpc_pkg::FRAMES || fr_pins[f] != 0) begin
            add_rsp(bpc_pkg::KIND_DONE, 0, q.file_id, q.page_number, 0, 0,
                    bpc_pkg::ST_NO_FRAME, 1);
            return;
          end
          if (fr_dirty[f]) add_writeback(f);
          frame_drop(f);
        end
        fr_valid[f] = 1; fr_dirty[f] = 0; fr_pins[f] = 0;
        fr_file[f] = q.file_id; fr_page[f] = q.page_number;
        list_append(f);
      end else begin
        list_unlink(f); list_append(f);
      end
      if (q.command == bpc_pkg::CMD_READ && fr_pins[f] < int'(bpc_pkg::PIN_MAX)) fr_pins[f]++;
      if (q.command == bpc_pkg::CMD_WRITE) fr_dirty[f] = 1;
      add_rsp(bpc_pkg::KIND_DONE, f, q.file_id, q.page_number, was_hit, !was_hit,
              bpc_pkg::ST_OK, 1);
    end else if (q.command == bpc_pkg::CMD_FREE || q.command == bpc_pkg::CMD_RELEASE) begin
      f = find_page(q.file_id, q.page_number);
      if (f == NONE)
        add_rsp(bpc_pkg::KIND_DONE, 0, q.file_id, q.page_number, 0, 0, bpc_pkg::ST_ABSENT, 1);
      else if (q.command == bpc_pkg::CMD_RELEASE) begin
        if (fr_pins[f] > 0) fr_pins[f]--;
        add_rsp(bpc_pkg::KIND_DONE, f, q.file_id, q.page_number, 1, 0, bpc_pkg::ST_OK, 1);
      end else if (fr_pins[f] != 0)
        add_rsp(bpc_pkg::KIND_DONE, f, q.file_id, q.page_number, 1, 0, bpc_pkg::ST_PINNED, 1);
      else begin
        if (fr_dirty[f]) add_writeback(f);
        frame_drop(f); free_push(f);
        add_rsp(bpc_pkg::KIND_DONE, f, q.file_id, q.page_number, 1, 0, bpc_pkg::ST_OK, 1);
      end
    end else if (q.command == bpc_pkg::CMD_FLUSH) begin
      st = bpc_pkg::ST_OK;
      for (f = 0; f < bpc_pkg::FRAMES; f++) begin
        if (!fr_valid[f] || fr_file[f] != q.file_id) continue;
        if (fr_dirty[f]) begin
          add_writeback(f); fr_dirty[f] = 0;
        end
        if (q.drop_after_flush) begin
          if (fr_pins[f] != 0) st = bpc_pkg::ST_PINNED;
          else begin
            frame_drop(f); free_push(f);
          end
        end
      end
      add_rsp(bpc_pkg::KIND_DONE, 0, q.file_id, '0, 0, 0, st, 1);
    end else
      add_rsp(bpc_pkg::KIND_DONE, 0, q.file_id, q.page_number, 0, 0, bpc_pkg::ST_OK, 1);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    bpc_pkg::rsp_t exp_r;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, rsp_o);
        fail_cnt++;
      end else begin
        exp_r = pending_rsp.pop_front();
        if (rsp_o.kind !== exp_r.kind || rsp_o.frame_no !== exp_r.frame_no ||
            rsp_o.out_file_id !== exp_r.out_file_id ||
            rsp_o.out_page_number !== exp_r.out_page_number ||
            rsp_o.hit !== exp_r.hit || rsp_o.fill_needed !== exp_r.fill_needed ||
            rsp_o.status !== exp_r.status || rsp_o.last !== exp_r.last) begin
          $display("%0t: result mismatch, expected %h, actual %h", $time, exp_r, rsp_o);
          fail_cnt++;
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // start stays high into the next item when it follows with no gap
  task automatic send_raw(bpc_pkg::req_t q);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_request(q);
  endtask

  task automatic send_req(bpc_pkg::cmd_e c, logic [bpc_pkg::FILE_W-1:0] fid,
                          logic [bpc_pkg::PAGE_W-1:0] pg, bit drop = 0);
    bpc_pkg::req_t q;
    q.command = c; q.file_id = fid; q.page_number = pg; q.drop_after_flush = drop;
    send_raw(q);
  endtask

  task automatic drain_pool();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_pool_size(logic [4:0] v);
    drain_pool();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pool_size = (v == 0) ? 1 : (v > bpc_pkg::FRAMES) ? bpc_pkg::FRAMES : int'(v);
    pool_clear();
  endtask

  task automatic test_basic_commands();
    send_req(bpc_pkg::CMD_READ, 4'h0, 32'h0);
    send_req(bpc_pkg::CMD_READ, 4'h0, 32'h0);
    send_req(bpc_pkg::CMD_WRITE, 4'hF, 32'hFFFF_FFFF);
    send_req(bpc_pkg::CMD_INSTALL, 4'h3, 32'h1234_5678);
    send_req(bpc_pkg::CMD_RELEASE, 4'h0, 32'h0);
    send_req(bpc_pkg::CMD_RELEASE, 4'h0, 32'h0);
    send_req(bpc_pkg::CMD_RELEASE, 4'h0, 32'h0);
    send_req(bpc_pkg::CMD_RELEASE, 4'h9, 32'h55);
    send_req(bpc_pkg::CMD_FREE, 4'hF, 32'hFFFF_FFFF);
    send_req(bpc_pkg::CMD_FREE, 4'h7, 32'h77);
    send_req(bpc_pkg::CMD_READ, 4'h3, 32'h1234_5678);
    send_req(bpc_pkg::CMD_FREE, 4'h3, 32'h1234_5678);
    send_req(bpc_pkg::CMD_WRITE, 4'h5, 32'hA);
    send_req(bpc_pkg::CMD_WRITE, 4'h5, 32'hB);
    send_req(bpc_pkg::CMD_FLUSH, 4'h5, 32'h0, 0);
    send_req(bpc_pkg::CMD_WRITE, 4'h5, 32'hA);
    send_req(bpc_pkg::CMD_FLUSH, 4'h5, 32'h0, 1);
    send_req(bpc_pkg::CMD_FLUSH, 4'h3, 32'hDEAD, 1);
    send_raw('{command: 3'd6, file_id: 4'hA, page_number: 32'hCAFE_F00D,
               drop_after_flush: 1'b1});
    send_raw('{command: 3'd7, file_id: 4'h1, page_number: 32'h1, drop_after_flush: 1'b0});
  endtask

  // tiny pool: eviction of dirty frames, all pinned, pin skip
  task automatic test_eviction();
    set_pool_size(5'd2);
    send_req(bpc_pkg::CMD_WRITE, 4'h1, 32'h10);
    send_req(bpc_pkg::CMD_READ, 4'h1, 32'h11);
    send_req(bpc_pkg::CMD_INSTALL, 4'h1, 32'h12);
    send_req(bpc_pkg::CMD_READ, 4'h1, 32'h12);
    send_req(bpc_pkg::CMD_INSTALL, 4'h2, 32'h20);
    send_req(bpc_pkg::CMD_RELEASE, 4'h1, 32'h11);
    send_req(bpc_pkg::CMD_WRITE, 4'h2, 32'h21);
    send_req(bpc_pkg::CMD_FLUSH, 4'h1, 32'h0, 1);
    set_pool_size(5'd0);
    send_req(bpc_pkg::CMD_WRITE, 4'h4, 32'h40);
    send_req(bpc_pkg::CMD_WRITE, 4'h4, 32'h41);
  endtask

  task automatic test_pin_saturation();
    set_pool_size(5'd31);
    for (int k = 0; k < 257; k++) send_raw('{command: bpc_pkg::CMD_READ, file_id: 4'h6,
                                             page_number: 32'h66, drop_after_flush: 1'b0});
    send_req(bpc_pkg::CMD_RELEASE, 4'h6, 32'h66);
    send_req(bpc_pkg::CMD_FREE, 4'h6, 32'h66);
  endtask

  task automatic test_random(logic [4:0] size, int count);
    bpc_pkg::req_t q;
    int  sel;
    set_pool_size(size);
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      q.file_id = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
      q.page_number = ($urandom_range(0, 4) == 0) ? $urandom
                      : {$urandom_range(0, 1) ? 28'hFFF_FFFF : 28'h0,
                         4'($urandom_range(0, 7))};
      q.drop_after_flush = $urandom_range(0, 1);
      if (sel < 30) q.command = bpc_pkg::CMD_READ;
      else if (sel < 50) q.command = bpc_pkg::CMD_WRITE;
      else if (sel < 60) q.command = bpc_pkg::CMD_INSTALL;
      else if (sel < 72) q.command = bpc_pkg::CMD_FREE;
      else if (sel < 90) q.command = bpc_pkg::CMD_RELEASE;
      else if (sel < 97) q.command = bpc_pkg::CMD_FLUSH;
      else q.command = 3'($urandom_range(6, 7));
      send_raw(q);
    end
  endtask

  initial begin
    pool_size = bpc_pkg::FRAMES;
    pool_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_commands();
    test_eviction();
    test_pin_saturation();
    test_random(5'd3, 12);
    test_random(5'd16, 12);
    test_random(5'd1, 6);
    test_random(5'd7, 12);
    drain_pool();
    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bpc_pkg.sv
rtl/core/bpc_rec_mem.sv
rtl/core/bpc_lru.sv
rtl/core/bpc_free_stack.sv
rtl/core/lru_page_buffer_pool_controller.sv
tb/lru_page_buffer_pool_controller_tb.sv
